// ----- sv/bbr_pkg.sv -----
package bbr_pkg;

  localparam int PIX_W          = 8;
  localparam int CSUM_W         = 10;
  localparam int SUM_W          = 12;
  localparam int PROD_W         = 25;
  localparam int WIN_N          = 3;
  localparam int MIN_DIM        = 2;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 13;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Rounded means: (sum + n/2) / n, with the divisions by six and nine done as a
  // multiplication by a scaled reciprocal that is exact over the reachable sums.
  localparam int              RECIP_SHIFT = 15;
  localparam logic [12:0]     RECIP_6     = 13'd5462;
  localparam logic [12:0]     RECIP_9     = 13'd3641;
  localparam int              DIV4_SHIFT  = 2;
  localparam logic [SUM_W-1:0] HALF_4     = 12'd2;
  localparam logic [SUM_W-1:0] HALF_6     = 12'd3;
  localparam logic [SUM_W-1:0] HALF_9     = 12'd4;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } bbr_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bbr_reg_e;

  typedef enum logic [1:0] {
    CNT_4,
    CNT_6,
    CNT_9
  } bbr_cnt_e;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } bbr_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             row_end;
    logic             frame_end;
  } bbr_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } bbr_px_t;

  // Index 0 is the top row of a window column.
  typedef bbr_px_t [WIN_N-1:0] bbr_col_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } bbr_csum_t;

  typedef struct packed {
    logic emit;
    logic flush;
    logic first_row;
    logic last_row;
    logic first_col;
    logic last_col;
  } bbr_s1_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    bbr_cnt_e         cnt;
    logic             row_end;
    logic             frame_end;
  } bbr_s2_t;

endpackage

// ----- sv/bbr_stream_if.sv -----
interface bbr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/bbr_ram.sv -----
module bbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- sv/bbr_cell.sv -----
module bbr_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               skip_top_i,
  input  logic               skip_bot_i,
  input  bbr_pkg::bbr_col_t  col_i,
  output bbr_pkg::bbr_col_t  col_o,
  output bbr_pkg::bbr_csum_t sum_o
);
  import bbr_pkg::*;

  bbr_col_t col_q;
  bbr_px_t  top_px;
  bbr_px_t  bot_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  // Column sum over the rows that lie inside the frame.
  always_comb begin
    top_px = skip_top_i ? '0 : col_q[0];
    bot_px = skip_bot_i ? '0 : col_q[WIN_N-1];
    sum_o.red   = CSUM_W'(top_px.red) + CSUM_W'(col_q[1].red) + CSUM_W'(bot_px.red);
    sum_o.green = CSUM_W'(top_px.green) + CSUM_W'(col_q[1].green) + CSUM_W'(bot_px.green);
    sum_o.blue  = CSUM_W'(top_px.blue) + CSUM_W'(col_q[1].blue) + CSUM_W'(bot_px.blue);
  end

  assign col_o = col_q;
endmodule

// ----- sv/bbr_mean.sv -----
module bbr_mean (
  input  logic [bbr_pkg::SUM_W-1:0] sum_i,
  input  bbr_pkg::bbr_cnt_e         cnt_i,
  output logic [bbr_pkg::PIX_W-1:0] mean_o
);
  import bbr_pkg::*;

  logic [SUM_W-1:0]  x;
  logic [PROD_W-1:0] prod;

  always_comb begin
    x      = sum_i;
    prod   = '0;
    mean_o = '0;
    unique case (cnt_i)
      CNT_4: begin
        x      = sum_i + HALF_4;
        mean_o = x[DIV4_SHIFT +: PIX_W];
      end
      CNT_6: begin
        x      = sum_i + HALF_6;
        prod   = PROD_W'(x) * PROD_W'(RECIP_6);
        mean_o = prod[RECIP_SHIFT +: PIX_W];
      end
      CNT_9: begin
        x      = sum_i + HALF_9;
        prod   = PROD_W'(x) * PROD_W'(RECIP_9);
        mean_o = prod[RECIP_SHIFT +: PIX_W];
      end
      default: begin
        mean_o = '0;
      end
    endcase
  end
endmodule

// ----- sv/box_blur_3x3_rgb.sv -----
// Streaming 3x3 box blur of an RGB frame sent in raster order, one pixel per beat. Each result
// is the rounded mean of the in-frame neighbors (four at a corner, six on an edge, nine inside)
// and carries row_end and frame_end marks. The block takes one beat per clock unless pix_o
// stalls: every pixel beat does one read and one write on each of the two line stores
// (MAX_WIDTH x 24 bits, no clearing pass after reset) and shifts one column into a chain of
// three window cells. A result leaves frame_width+2 beats behind its pixel. After the last
// pixel of a frame, send frame_width+2 flush beats to drain the remaining results; a pixel sent
// once draining has begun starts the next frame and drops whatever is still pending. Frames
// must be at least 2x2; write frame_width and frame_height only while the block is idle.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bbr_stream_if.sink                     pix_i,
  bbr_stream_if.source                   pix_o
);
  import bbr_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int PW    = $clog2(MAX_WIDTH + 3);
  localparam int PXW   = $bits(bbr_px_t);
  localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  logic [CW:0]    w_q, w_d;
  logic [RW:0]    h_q, h_d;
  logic [31:0]    wv, hv;
  logic [CW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [PW-1:0]  pend_q, pend_d, pend_v, wp2;
  logic           drain_q, drain_d;

  logic [CW-1:0]  ic_n, oc_n, ocol, rd_addr;
  logic [RW-1:0]  ir_n, orow_n, orow;
  logic [CW:0]    fl_col;
  logic           active, emit, is_flush;
  logic           first_row, last_row, first_col, last_col;

  logic           rdy1, rdy2, rdy3, in_fire, s1_fire;
  logic           v1_q, v2_q, v3_q;
  bbr_s1_t        s1_new, s1_q;
  bbr_px_t        pix_new, pix1_q;
  logic [CW-1:0]  addr1_q;
  bbr_s2_t        s2_new, s2_q;
  bbr_out_t       out_new, out_q;

  logic           ram_re, ram_we;
  logic [PXW-1:0] up_rd, mid_rd;
  bbr_px_t        up_eff, mid_eff;
  logic           byp_q;
  bbr_px_t        byp_up_q, byp_mid_q;

  bbr_col_t       new_col;
  bbr_col_t       win_col [WIN_N+1];
  bbr_csum_t      col_sum [WIN_N];
  bbr_csum_t      lsum, rsum;
  logic           rows2, cols2;

  // Frame size registers hold the clamped size.
  always_comb begin
    w_d = w_q;
    h_d = h_q;
    wv  = 32'(cfg_data_i[FRAME_WIDTH_W-1:0]);
    hv  = 32'(cfg_data_i[FRAME_HEIGHT_W-1:0]);
    if (wv < 32'(MIN_DIM)) begin
      wv = 32'(MIN_DIM);
    end else if (wv > 32'(MAX_WIDTH)) begin
      wv = 32'(MAX_WIDTH);
    end
    if (hv < 32'(MIN_DIM)) begin
      hv = 32'(MIN_DIM);
    end else if (hv > 32'(MAX_HEIGHT)) begin
      hv = 32'(MAX_HEIGHT);
    end
    if (cfg_we_i) begin
      unique case (bbr_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  w_d = (CW+1)'(wv);
        REG_FRAME_HEIGHT: h_d = (RW+1)'(hv);
      endcase
    end
  end

  assign rdy3        = !v3_q || pix_o.ready;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pix_i.ready = rdy1;
  assign in_fire     = pix_i.valid && rdy1;
  assign s1_fire     = v1_q && rdy2;

  // Positions left beyond a smaller frame size count as zero.
  always_comb begin
    ic_n   = ({1'b0, in_col_q} >= w_q) ? '0 : in_col_q;
    ir_n   = ({1'b0, in_row_q} >= h_q) ? '0 : in_row_q;
    oc_n   = ({1'b0, out_col_q} >= w_q) ? '0 : out_col_q;
    orow_n = ({1'b0, out_row_q} >= h_q) ? '0 : out_row_q;
    wp2    = PW'(w_q) + PW'(2);
    fl_col = {1'b0, oc_n} + (CW+1)'(2);
    if (fl_col >= w_q) begin
      fl_col = fl_col - w_q;
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    drain_d   = drain_q;
    pend_v    = pend_q;
    ocol      = oc_n;
    orow      = orow_n;
    rd_addr   = ic_n;
    active    = 1'b0;
    emit      = 1'b0;
    is_flush  = (pix_i.data.operation == OP_FLUSH);
    if (in_fire) begin
      in_col_d  = ic_n;
      in_row_d  = ir_n;
      out_col_d = oc_n;
      out_row_d = orow_n;
      if (is_flush) begin
        if (ic_n == '0 && ir_n == '0 && pend_q != '0) begin
          active  = 1'b1;
          emit    = 1'b1;
          rd_addr = fl_col[CW-1:0];
          pend_d  = pend_q - PW'(1);
          drain_d = 1'b1;
        end
      end else begin
        active = 1'b1;
        if (drain_q) begin
          pend_v  = '0;
          ocol    = '0;
          orow    = '0;
          drain_d = 1'b0;
        end
        out_col_d = ocol;
        out_row_d = orow;
        if (pend_v >= wp2) begin
          emit   = 1'b1;
          pend_d = wp2;
        end else begin
          pend_d = pend_v + PW'(1);
        end
        if ({1'b0, ic_n} + (CW+1)'(1) >= w_q) begin
          in_col_d = '0;
          in_row_d = ({1'b0, ir_n} + (RW+1)'(1) >= h_q) ? '0 : ir_n + RW'(1);
        end else begin
          in_col_d = ic_n + CW'(1);
        end
      end
    end
    first_row = (orow == '0);
    last_row  = ({1'b0, orow} + (RW+1)'(1) >= h_q);
    first_col = (ocol == '0);
    last_col  = ({1'b0, ocol} + (CW+1)'(1) >= w_q);
    if (in_fire && emit) begin
      if (last_col) begin
        out_col_d = '0;
        out_row_d = last_row ? '0 : orow + RW'(1);
      end else begin
        out_col_d = ocol + CW'(1);
      end
    end
    s1_new.emit      = emit;
    s1_new.flush     = is_flush;
    s1_new.first_row = first_row;
    s1_new.last_row  = last_row;
    s1_new.first_col = first_col;
    s1_new.last_col  = last_col;
    pix_new.red      = pix_i.data.in_red;
    pix_new.green    = pix_i.data.in_green;
    pix_new.blue     = pix_i.data.in_blue;
  end

  assign ram_re = in_fire && active;
  assign ram_we = s1_fire && !s1_q.flush;

  bbr_ram #(
    .WIDTH (PXW),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr1_q),
    .wdata_i (mid_eff),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (up_rd)
  );

  bbr_ram #(
    .WIDTH (PXW),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr1_q),
    .wdata_i (pix1_q),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (mid_rd)
  );

  // A read of the column that the previous beat writes in the same cycle takes the new data.
  assign up_eff  = byp_q ? byp_up_q : bbr_px_t'(up_rd);
  assign mid_eff = byp_q ? byp_mid_q : bbr_px_t'(mid_rd);

  always_comb begin
    new_col[0]       = up_eff;
    new_col[1]       = mid_eff;
    new_col[WIN_N-1] = s1_q.flush ? '0 : pix1_q;
  end

  assign win_col[WIN_N] = new_col;

  for (genvar k = 0; k < WIN_N; k++) begin : g_cell
    bbr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (s1_fire),
      .skip_top_i (s1_q.first_row),
      .skip_bot_i (s1_q.last_row),
      .col_i      (win_col[k+1]),
      .col_o      (win_col[k]),
      .sum_o      (col_sum[k])
    );
  end

  always_comb begin
    lsum  = s1_q.first_col ? '0 : col_sum[0];
    rsum  = s1_q.last_col ? '0 : col_sum[WIN_N-1];
    rows2 = s1_q.first_row || s1_q.last_row;
    cols2 = s1_q.first_col || s1_q.last_col;
    s2_new.sum_red   = SUM_W'(lsum.red) + SUM_W'(col_sum[1].red) + SUM_W'(rsum.red);
    s2_new.sum_green = SUM_W'(lsum.green) + SUM_W'(col_sum[1].green) + SUM_W'(rsum.green);
    s2_new.sum_blue  = SUM_W'(lsum.blue) + SUM_W'(col_sum[1].blue) + SUM_W'(rsum.blue);
    priority if (rows2 && cols2) begin
      s2_new.cnt = CNT_4;
    end else if (rows2 || cols2) begin
      s2_new.cnt = CNT_6;
    end else begin
      s2_new.cnt = CNT_9;
    end
    s2_new.row_end   = s1_q.last_col;
    s2_new.frame_end = s1_q.last_col && s1_q.last_row;
  end

  bbr_mean u_mean_red (
    .sum_i  (s2_q.sum_red),
    .cnt_i  (s2_q.cnt),
    .mean_o (out_new.out_red)
  );

  bbr_mean u_mean_green (
    .sum_i  (s2_q.sum_green),
    .cnt_i  (s2_q.cnt),
    .mean_o (out_new.out_green)
  );

  bbr_mean u_mean_blue (
    .sum_i  (s2_q.sum_blue),
    .cnt_i  (s2_q.cnt),
    .mean_o (out_new.out_blue)
  );

  assign out_new.row_end   = s2_q.row_end;
  assign out_new.frame_end = s2_q.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= (CW+1)'(W_RST);
      h_q       <= (RW+1)'(H_RST);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
      drain_q   <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      byp_q     <= 1'b0;
    end else begin
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
      drain_q   <= drain_d;
      if (rdy1) begin
        v1_q <= in_fire && active;
      end
      if (rdy2) begin
        v2_q <= v1_q && s1_q.emit;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (ram_re) begin
        byp_q <= ram_we && (addr1_q == rd_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && active) begin
      s1_q    <= s1_new;
      pix1_q  <= pix_new;
      addr1_q <= rd_addr;
    end
    if (ram_re) begin
      byp_up_q  <= mid_eff;
      byp_mid_q <= pix1_q;
    end
    if (s1_fire && s1_q.emit) begin
      s2_q <= s2_new;
    end
    if (v2_q && rdy3) begin
      out_q <= out_new;
    end
  end

  assign pix_o.valid = v3_q;
  assign pix_o.data  = out_q;

`ifndef SYNTHESIS
  a_flush_at_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && s1_q.flush |-> in_col_q == '0 && in_row_q == '0)
    else $error("Flush beat in the window stage while the input is not at frame start.");

  a_drain_at_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> in_col_q == '0 && in_row_q == '0)
    else $error("Drain in progress while the input position has moved.");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PW'(MAX_WIDTH + 2))
    else $error("Pending count beyond one line plus two pixels.");

  a_frame_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && pix_o.data.frame_end |-> pix_o.data.row_end)
    else $error("Frame end marked on a result that does not end its row.");
`endif

endmodule

// ----- dv/box_blur_3x3_rgb_test.sv -----
module box_blur_3x3_rgb_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bbr_pkg::*;

  localparam int LINE_DEPTH     = 1024;
  localparam int LINE_ROWS      = 4096;
  localparam int WIDE_W         = 96;
  localparam int SETTLE         = 16;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BEATS   = 650;
  localparam int PLAN_N         = 24;

  typedef struct packed {
    bbr_op_e          op;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             typed;
    bbr_out_t         want;
  } plan_row_t;

  // A 2x2 frame is all corners, so each of its results is the rounded mean of the frame.
  localparam plan_row_t PLAN [PLAN_N] = '{
    '{OP_PIXEL, 8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{OP_PIXEL, 8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{OP_PIXEL, 8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{OP_PIXEL, 8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd255, 8'd0, 8'd1, 1'b0, 1'b0}},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd255, 8'd0, 8'd1, 1'b1, 1'b0}},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd255, 8'd0, 8'd1, 1'b0, 1'b0}},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd255, 8'd0, 8'd1, 1'b1, 1'b1}},
    '{OP_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{OP_PIXEL, 8'd0,   8'd255, 8'd128, 1'b0, '0},
    '{OP_FLUSH, 8'd17,  8'd34,  8'd51,  1'b0, '0},
    '{OP_PIXEL, 8'd255, 8'd0,   8'd127, 1'b0, '0},
    '{OP_PIXEL, 8'd1,   8'd254, 8'd0,   1'b0, '0},
    '{OP_PIXEL, 8'd254, 8'd1,   8'd255, 1'b0, '0},
    '{OP_PIXEL, 8'd85,  8'd170, 8'd15,  1'b0, '0},
    '{OP_PIXEL, 8'd170, 8'd85,  8'd240, 1'b0, '0},
    '{OP_PIXEL, 8'd128, 8'd127, 8'd255, 1'b0, '0},
    '{OP_PIXEL, 8'd127, 8'd128, 8'd0,   1'b0, '0},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bbr_stream_if #(.T(bbr_in_t))  pix_in ();
  bbr_stream_if #(.T(bbr_out_t)) pix_out ();

  box_blur_3x3_rgb u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_in),
    .pix_o      (pix_out)
  );

  bbr_px_t     upper_mem  [LINE_DEPTH];
  bbr_px_t     middle_mem [LINE_DEPTH];
  bbr_px_t     win        [3][3];
  int unsigned in_row, in_col, out_row, out_col;
  int unsigned pixels_held;
  bit          drained_some;
  int unsigned frame_w, frame_h;

  bbr_out_t    blurs_due [$];
  int unsigned fault_cnt;
  int unsigned beat_cnt;
  bit          steady;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void win_shift(bbr_px_t top, bbr_px_t mid, bbr_px_t bot);
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
  endfunction

  function automatic bbr_out_t blur_emit();
    int unsigned r0, r1, c0, c1, cnt, sr, sg, sb;
    bit          last_col, last_row;
    bbr_out_t    res;
    r0 = (out_row > 0) ? 0 : 1;
    r1 = (out_row + 1 < frame_h) ? 2 : 1;
    c0 = (out_col > 0) ? 0 : 1;
    c1 = (out_col + 1 < frame_w) ? 2 : 1;
    cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
    sr = 0;
    sg = 0;
    sb = 0;
    for (int r = r0; r <= r1; r++) begin
      for (int c = c0; c <= c1; c++) begin
        sr += win[r][c].red;
        sg += win[r][c].green;
        sb += win[r][c].blue;
      end
    end
    last_col = (out_col + 1 >= frame_w);
    last_row = (out_row + 1 >= frame_h);
    res.out_red   = PIX_W'((sr + cnt / 2) / cnt);
    res.out_green = PIX_W'((sg + cnt / 2) / cnt);
    res.out_blue  = PIX_W'((sb + cnt / 2) / cnt);
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    if (last_col) begin
      out_col = 0;
      out_row = last_row ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
    return res;
  endfunction

  function automatic bit blur_step(input bbr_in_t beat, output bbr_out_t res);
    bbr_px_t     pix, top, mid;
    int unsigned col;
    bit          emitted;
    res = '0;
    emitted = 1'b0;
    if (in_col >= frame_w) in_col = 0;
    if (in_row >= frame_h) in_row = 0;
    if (out_col >= frame_w) out_col = 0;
    if (out_row >= frame_h) out_row = 0;
    if (beat.operation == OP_FLUSH) begin
      if (in_row != 0 || in_col != 0 || pixels_held == 0) return 1'b0;
      col = (out_col + 2) % frame_w;
      res = blur_emit();
      win_shift(upper_mem[col], middle_mem[col], '0);
      pixels_held--;
      drained_some = 1'b1;
      return 1'b1;
    end
    if (drained_some) begin
      pixels_held = 0;
      out_row = 0;
      out_col = 0;
      drained_some = 1'b0;
    end
    pix = {beat.in_red, beat.in_green, beat.in_blue};
    top = upper_mem[in_col];
    mid = middle_mem[in_col];
    upper_mem[in_col] = mid;
    middle_mem[in_col] = pix;
    if (pixels_held >= frame_w + 2) begin
      res = blur_emit();
      pixels_held = frame_w + 2;
      emitted = 1'b1;
    end else begin
      pixels_held++;
    end
    win_shift(top, mid, pix);
    if (in_col + 1 >= frame_w) begin
      in_col = 0;
      in_row = (in_row + 1 >= frame_h) ? 0 : in_row + 1;
    end else begin
      in_col++;
    end
    return emitted;
  endfunction

  function automatic bbr_in_t flush_beat();
    bbr_in_t beat;
    beat = bbr_in_t'($urandom);
    beat.operation = OP_FLUSH;
    return beat;
  endfunction

  function automatic bbr_in_t random_pixel(int unsigned flavor);
    bbr_in_t    beat;
    logic [7:0] v [3];
    for (int k = 0; k < 3; k++) begin
      case (flavor)
        4: v[k] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        5: v[k] = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 3)) : 8'($urandom_range(0, 3));
        default: v[k] = 8'($urandom);
      endcase
    end
    beat.operation = OP_PIXEL;
    beat.in_red    = v[0];
    beat.in_green  = v[1];
    beat.in_blue   = v[2];
    return beat;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_cnt++;
    end
  endfunction

  task automatic offer_beat(input bbr_in_t beat, input bit typed, input bbr_out_t want);
    bbr_out_t res;
    bit       emitted;
    if (!steady && $urandom_range(0, 4) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.data  <= beat;
    do @(posedge clk_i); while (!pix_in.ready);
    emitted = blur_step(beat, res);
    if (typed && !emitted) begin
      $error("directed beat was expected to produce a result");
      fault_cnt++;
    end
    if (emitted) blurs_due.push_back(typed ? want : res);
    if (beat.operation == OP_PIXEL || emitted) beat_cnt++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    pix_in.valid <= 1'b0;
    while (blurs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_for_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(negedge clk_i);
    cfg_idx  <= REG_FRAME_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    frame_w = (w < MIN_DIM) ? MIN_DIM : (w > LINE_DEPTH) ? LINE_DEPTH : w;
    frame_h = (h < MIN_DIM) ? MIN_DIM : (h > LINE_ROWS) ? LINE_ROWS : h;
  endtask

  task automatic drain_frame();
    while (pixels_held != 0) offer_beat(flush_beat(), 1'b0, '0);
  endtask

  task automatic run_frames(input int unsigned w, input int unsigned h,
                            input int unsigned frames, input bit squeeze);
    int unsigned flavor;
    set_frame(w, h);
    if (squeeze) hold_req = 1'b1;
    for (int unsigned f = 0; f < frames; f++) begin
      flavor = $urandom_range(0, 5);
      for (int unsigned i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 40) == 0) offer_beat(flush_beat(), 1'b0, '0);
        if (squeeze && f == 0 && i == w * h / 2) wait_for_results();
        offer_beat(random_pixel(flavor), 1'b0, '0);
      end
      if (f + 1 == frames) begin
        drain_frame();
      end else begin
        case ($urandom_range(0, 2))
          1: repeat ($urandom_range(1, pixels_held - 1)) offer_beat(flush_beat(), 1'b0, '0);
          2: begin
            drain_frame();
            if ($urandom_range(0, 1)) offer_beat(flush_beat(), 1'b0, '0);
          end
          default: ;
        endcase
      end
    end
  endtask

  always @(posedge clk_i) begin
    bbr_out_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (blurs_due.size() == 0) begin
        $error("result beat with no result expected: %p", pix_out.data);
        fault_cnt++;
      end else begin
        want = blurs_due.pop_front();
        check_field("out_red", want.out_red, pix_out.data.out_red);
        check_field("out_green", want.out_green, pix_out.data.out_green);
        check_field("out_blue", want.out_blue, pix_out.data.out_blue);
        check_field("row_end", want.row_end, pix_out.data.row_end);
        check_field("frame_end", want.frame_end, pix_out.data.frame_end);
      end
    end
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        pix_out.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
        pix_out.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned rand_base, w, h;
    bbr_in_t     beat;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_FRAME_WIDTH;
    cfg_data     = '0;
    pix_in.valid = 1'b0;
    pix_in.data  = '0;
    fault_cnt    = 0;
    beat_cnt     = 0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    foreach (upper_mem[i]) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    in_row       = 0;
    in_col       = 0;
    out_row      = 0;
    out_col      = 0;
    pixels_held  = 0;
    drained_some = 1'b0;
    frame_w      = FRAME_WIDTH_RST;
    frame_h      = FRAME_HEIGHT_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_frame(MIN_DIM, MIN_DIM);
    foreach (PLAN[i]) begin
      beat.operation = PLAN[i].op;
      beat.in_red    = PLAN[i].red;
      beat.in_green  = PLAN[i].green;
      beat.in_blue   = PLAN[i].blue;
      offer_beat(beat, PLAN[i].typed, PLAN[i].want);
    end
    drain_frame();

    run_frames(WIDE_W, MIN_DIM, 1, 1'b0);

    // The rows already streamed into the tall frame lie beyond the new height and wrap to zero.
    set_frame(MIN_DIM, LINE_ROWS);
    repeat (80) offer_beat(random_pixel(0), 1'b0, '0);
    run_frames(MIN_DIM, 3, 2, 1'b0);

    steady = 1'b1;
    run_frames(5, 20, 2, 1'b1);

    rand_base = beat_cnt;
    while (beat_cnt - rand_base < RANDOM_BEATS) begin
      steady = (beat_cnt - rand_base + 200 > RANDOM_BEATS) || ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 24) : $urandom_range(2, 9);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(2, 7);
      run_frames(w, h, $urandom_range(1, 3), 1'b0);
    end

    wait_for_results();
    if (fault_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bbr_pkg.sv
sv/bbr_stream_if.sv
sv/bbr_ram.sv
sv/bbr_cell.sv
sv/bbr_mean.sv
sv/box_blur_3x3_rgb.sv
dv/box_blur_3x3_rgb_test.sv
